// ===== hw/rtl/circle_canvas_rasterizer_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the circle canvas rasteriser
// Clocked on clk, disabled while rst is high.
// ---------------------------------------------------------------------------
`ifndef CIRCLE_CANVAS_RASTERIZER_MACROS_SVH
`define CIRCLE_CANVAS_RASTERIZER_MACROS_SVH

// same-cycle implication
`define CCR_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ccr assertion failed");

// next-cycle implication
`define CCR_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ccr assertion failed");

`endif

// ===== hw/rtl/ccr_pkg.sv =====
// ---------------------------------------------------------------------------
// ccr_pkg
// Shared types and constants of the circle canvas rasteriser.
// ---------------------------------------------------------------------------
package ccr_pkg;

  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_DRAW  = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_BG     = 2'd2;

  localparam logic [7:0] SHAPE_FILLED = 8'd67;  // 'C'
  localparam logic [7:0] SHAPE_RING   = 8'd99;  // 'c'

  localparam int ONE_Q8 = 256;
  localparam int ONE_Q16 = 65536;

  localparam logic [8:0] RESET_WIDTH  = 9'd256;
  localparam logic [8:0] RESET_HEIGHT = 9'd256;
  localparam logic [7:0] RESET_BG     = 8'd32;

  typedef enum logic [1:0] {
    SQ_CX,
    SQ_CY,
    SQ_R,
    SQ_RI
  } sq_sel_t;

  typedef struct packed {
    logic       we;
    logic [1:0] index;
    logic [8:0] wdata;
  } cfg_wr_t;

  typedef struct packed {
    logic    load;
    logic    init;
    logic    sq_en;
    sq_sel_t sq_sel;
    logic    sweep_clear;
    logic    sweep_draw;
    logic    rd_en;
    logic    out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic is_clear;
    logic is_draw;
    logic is_read;
    logic bad_draw;
    logic read_oob;
    logic dims_empty;
    logic col_last;
    logic row_last;
  } dp_status_t;

endpackage

// ===== hw/rtl/ccr_ram.sv =====
// ---------------------------------------------------------------------------
// ccr_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module ccr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/ccr_datapath.sv =====
// ---------------------------------------------------------------------------
// ccr_datapath
// Request latch, configuration, shared squarer, incremental distance
// sweep, canvas memory and result registers.
// ---------------------------------------------------------------------------
module ccr_datapath #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                 clk,
  input  logic                 rst,
  input  ccr_pkg::cfg_wr_t     cfg,
  input  logic [95:0]          s_tdata,
  input  logic [1:0]           s_tuser,
  input  ccr_pkg::dp_cmd_t     cmd,
  output ccr_pkg::dp_status_t  status,
  output logic [7:0]           pix_out,
  output logic                 err_out
);

  localparam int CW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int DWW  = ($clog2(MAX_WIDTH + 1) > 9) ? $clog2(MAX_WIDTH + 1) : 9;
  localparam int DWH  = ($clog2(MAX_HEIGHT + 1) > 9) ? $clog2(MAX_HEIGHT + 1) : 9;
  localparam int PW   = (CW > RW) ? CW : RW;
  localparam int DXW  = ((PW + 8 > 19) ? PW + 8 : 19) + 2;
  localparam int D2W  = 2 * DXW;
  localparam int AW   = CW + RW;

  localparam logic [DWW-1:0] MAXW = DWW'(MAX_WIDTH);
  localparam logic [DWH-1:0] MAXH = DWH'(MAX_HEIGHT);
  localparam logic signed [DXW-1:0] STEP_Q8  = DXW'(ccr_pkg::ONE_Q8);
  localparam logic signed [D2W-1:0] STEP_Q16 = D2W'(ccr_pkg::ONE_Q16);

  logic [8:0] cfg_width;
  logic [8:0] cfg_height;
  logic [7:0] bg;

  logic [1:0]         cmd_q;
  logic [7:0]         shape;
  logic signed [18:0] cx;
  logic signed [18:0] cy;
  logic signed [18:0] r;
  logic [7:0]         paint;
  logic [7:0]         rcol;
  logic [7:0]         rrow;

  logic [CW-1:0]         col;
  logic [RW-1:0]         row;
  logic signed [DXW-1:0] dx;
  logic signed [DXW-1:0] dy;
  logic signed [D2W-1:0] dx2;
  logic signed [D2W-1:0] dy2;
  logic signed [D2W-1:0] cx2;
  logic signed [D2W-1:0] outer;
  logic signed [D2W-1:0] inner;

  logic [DWW-1:0]        used_w;
  logic [DWH-1:0]        used_h;
  logic signed [DXW-1:0] cx_ext;
  logic signed [DXW-1:0] cy_ext;
  logic signed [19:0]    sq_op;
  logic signed [39:0]    sq;
  logic signed [D2W-1:0] dx_inc;
  logic signed [D2W-1:0] dy_inc;
  logic signed [D2W-1:0] d2;
  logic                  has_inner;
  logic                  hit;
  logic                  step;
  logic                  ram_we;
  logic [7:0]            ram_wdata;
  logic [7:0]            ram_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_width  <= ccr_pkg::RESET_WIDTH;
      cfg_height <= ccr_pkg::RESET_HEIGHT;
      bg         <= ccr_pkg::RESET_BG;
    end else if (cfg.we) begin
      case (cfg.index)
        ccr_pkg::CFG_WIDTH:  cfg_width  <= cfg.wdata;
        ccr_pkg::CFG_HEIGHT: cfg_height <= cfg.wdata;
        ccr_pkg::CFG_BG:     bg         <= cfg.wdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_q <= s_tuser;
      shape <= s_tdata[7:0];
      cx    <= s_tdata[26:8];
      cy    <= s_tdata[45:27];
      r     <= s_tdata[64:46];
      paint <= s_tdata[72:65];
      rcol  <= s_tdata[80:73];
      rrow  <= s_tdata[88:81];
    end
  end

  assign used_w = (DWW'(cfg_width) > MAXW) ? MAXW : DWW'(cfg_width);
  assign used_h = (DWH'(cfg_height) > MAXH) ? MAXH : DWH'(cfg_height);

  assign cx_ext = DXW'(cx);
  assign cy_ext = DXW'(cy);

  always_comb begin
    case (cmd.sq_sel)
      ccr_pkg::SQ_CX: sq_op = 20'(cx);
      ccr_pkg::SQ_CY: sq_op = 20'(cy);
      ccr_pkg::SQ_R:  sq_op = 20'(r);
      ccr_pkg::SQ_RI: sq_op = 20'(r) - 20'sd256;
      default:        sq_op = 20'(r);
    endcase
  end

  assign sq     = sq_op * sq_op;
  assign dx_inc = (D2W'(dx) <<< 9) + STEP_Q16;
  assign dy_inc = (D2W'(dy) <<< 9) + STEP_Q16;
  assign d2     = dx2 + dy2;

  assign has_inner = (shape == ccr_pkg::SHAPE_RING) && (r >= 19'sd256);
  assign hit       = (d2 <= outer) && (!has_inner || (d2 > inner));
  assign step      = cmd.sweep_clear || cmd.sweep_draw;

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      col <= '0;
      row <= '0;
      dx  <= -cx_ext;
      dy  <= -cy_ext;
    end else if (step) begin
      if (status.col_last) begin
        col <= '0;
        dx  <= -cx_ext;
        dx2 <= cx2;
        row <= row + 1'b1;
        dy  <= dy + STEP_Q8;
        dy2 <= dy2 + dy_inc;
      end else begin
        col <= col + 1'b1;
        dx  <= dx + STEP_Q8;
        dx2 <= dx2 + dx_inc;
      end
    end
    if (cmd.sq_en) begin
      case (cmd.sq_sel)
        ccr_pkg::SQ_CX: begin
          cx2 <= D2W'(sq);
          dx2 <= D2W'(sq);
        end
        ccr_pkg::SQ_CY: dy2   <= D2W'(sq);
        ccr_pkg::SQ_R:  outer <= D2W'(sq);
        ccr_pkg::SQ_RI: inner <= D2W'(sq);
        default: ;
      endcase
    end
  end

  assign status.is_clear   = (cmd_q == ccr_pkg::CMD_CLEAR);
  assign status.is_draw    = (cmd_q == ccr_pkg::CMD_DRAW);
  assign status.is_read    = (cmd_q == ccr_pkg::CMD_READ);
  assign status.bad_draw   = ((shape != ccr_pkg::SHAPE_FILLED) && (shape != ccr_pkg::SHAPE_RING))
                             || r[18] || (r == 19'sd0);
  assign status.read_oob   = (DWW'(rcol) >= used_w) || (DWH'(rrow) >= used_h);
  assign status.dims_empty = (used_w == '0) || (used_h == '0);
  assign status.col_last   = ((DWW'(col) + DWW'(1)) == used_w);
  assign status.row_last   = ((DWH'(row) + DWH'(1)) == used_h);

  assign ram_we    = cmd.sweep_clear || (cmd.sweep_draw && hit);
  assign ram_wdata = cmd.sweep_clear ? bg : paint;

  ccr_ram #(
    .WIDTH (8),
    .DEPTH (2 ** AW)
  ) u_canvas (
    .clk   (clk),
    .we    (ram_we),
    .waddr ({row, col}),
    .wdata (ram_wdata),
    .re    (cmd.rd_en),
    .raddr ({RW'(rrow), CW'(rcol)}),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      pix_out <= (status.is_read && !status.read_oob) ? ram_rdata : 8'd0;
      err_out <= (status.is_draw && status.bad_draw) || (status.is_read && status.read_oob);
    end
  end

endmodule

// ===== hw/rtl/ccr_ctrl.sv =====
// ---------------------------------------------------------------------------
// ccr_ctrl
// Sequencer: decode, squarer steps, pixel sweep, read and result hand-off.
// ---------------------------------------------------------------------------
`include "circle_canvas_rasterizer_macros.svh"

module ccr_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  output logic                m_tvalid,
  input  logic                m_tready,
  input  ccr_pkg::dp_status_t status,
  output ccr_pkg::dp_cmd_t    cmd
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SQ_CX,
    ST_SQ_CY,
    ST_SQ_R,
    ST_SQ_RI,
    ST_DRAW,
    ST_CLEAR,
    ST_READ,
    ST_DONE
  } state_t;

  state_t state;

  assign s_tready = (state == ST_IDLE);

  always_comb begin
    cmd = '0;
    case (state)
      ST_IDLE:   cmd.load = s_tvalid;
      ST_DECODE: cmd.init = 1'b1;
      ST_SQ_CX: begin
        cmd.sq_en  = 1'b1;
        cmd.sq_sel = ccr_pkg::SQ_CX;
      end
      ST_SQ_CY: begin
        cmd.sq_en  = 1'b1;
        cmd.sq_sel = ccr_pkg::SQ_CY;
      end
      ST_SQ_R: begin
        cmd.sq_en  = 1'b1;
        cmd.sq_sel = ccr_pkg::SQ_R;
      end
      ST_SQ_RI: begin
        cmd.sq_en  = 1'b1;
        cmd.sq_sel = ccr_pkg::SQ_RI;
      end
      ST_DRAW:  cmd.sweep_draw  = 1'b1;
      ST_CLEAR: cmd.sweep_clear = 1'b1;
      ST_READ:  cmd.rd_en       = 1'b1;
      ST_DONE:  cmd.out_load    = !m_tvalid || m_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && !cmd.out_load) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) state <= ST_DECODE;
        end
        ST_DECODE: begin
          if (status.is_clear) begin
            state <= status.dims_empty ? ST_DONE : ST_CLEAR;
          end else if (status.is_draw) begin
            state <= (status.bad_draw || status.dims_empty) ? ST_DONE : ST_SQ_CX;
          end else if (status.is_read) begin
            state <= status.read_oob ? ST_DONE : ST_READ;
          end else begin
            state <= ST_DONE;
          end
        end
        ST_SQ_CX: state <= ST_SQ_CY;
        ST_SQ_CY: state <= ST_SQ_R;
        ST_SQ_R:  state <= ST_SQ_RI;
        ST_SQ_RI: state <= ST_DRAW;
        ST_DRAW, ST_CLEAR: begin
          if (status.col_last && status.row_last) state <= ST_DONE;
        end
        ST_READ: state <= ST_DONE;
        ST_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `CCR_ASSERT_IMPL(a_no_overwrite, cmd.out_load, !m_tvalid || m_tready)
  `CCR_ASSERT_IMPL(a_draw_valid, state == ST_DRAW, !status.bad_draw && !status.dims_empty)
  `CCR_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
  `CCR_ASSERT_NEXT(a_result_after_load, cmd.out_load, m_tvalid)

endmodule

// ===== hw/rtl/circle_canvas_rasterizer.sv =====
// ---------------------------------------------------------------------------
// circle_canvas_rasterizer
// Byte canvas with clear, filled / outline circle draw and pixel read.
//
// Channel  Dir  Handshake          Content
// s_*      in   s_tvalid/s_tready  one request: command in tuser, operands in tdata
// m_*      out  m_tvalid/m_tready  one result per request: pixel in tdata, error in tuser
// cfg_*    in   cfg_we             register write, index and data
//
// Clear and draw sweep the canvas; read, rejected or empty requests skip the
// sweep. The sweep handles one canvas pixel per cycle.
// Distances are updated incrementally, the squarer runs only in setup.
// The canvas is undefined after reset until cleared; no clearing pass.
// A held result stalls the next hand-off; the next request is still taken at once.
// ---------------------------------------------------------------------------
module circle_canvas_rasterizer #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // shape_char, center_x, center_y, radius, paint_char, read_col, read_row
  input  logic [95:0] s_tdata,
  // command
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // pixel_char
  output logic [7:0]  m_tdata,
  // error
  output logic [0:0]  m_tuser,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_wdata
);

  ccr_pkg::cfg_wr_t    cfg;
  ccr_pkg::dp_cmd_t    cmd;
  ccr_pkg::dp_status_t status;

  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.wdata = cfg_wdata;

  ccr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  ccr_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .cmd     (cmd),
    .status  (status),
    .pix_out (m_tdata),
    .err_out (m_tuser[0])
  );

endmodule

// ===== verif/canvas_checker.sv =====
// ----------------------------------------------------------------------------
// canvas_checker
// Watches the request, result and register ports of the circle canvas
// rasteriser, keeps its own copy of the canvas and registers, works out the
// pixel and error each accepted request must return and compares them, in
// order, with the results the block hands off.
// ----------------------------------------------------------------------------
module canvas_checker
  import ccr_pkg::*;
#(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  // shape_char, center_x, center_y, radius, paint_char, read_col, read_row
  input  logic [95:0] s_tdata,
  // command
  input  logic [1:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  // pixel_char
  input  logic [7:0]  m_tdata,
  // error
  input  logic [0:0]  m_tuser,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_wdata,
  output int          fail_count,
  output int          outstanding
);

  typedef struct {
    logic [1:0]         cmd;
    logic [7:0]         shape;
    logic signed [18:0] cx;
    logic signed [18:0] cy;
    logic signed [18:0] radius;
    logic [7:0]         paint;
    logic [7:0]         col;
    logic [7:0]         row;
  } canvas_req_t;

  typedef struct packed {
    logic [7:0] pixel;
    logic       err;
  } pixel_result_t;

  logic [7:0]    canvas_mem [0:MAX_WIDTH*MAX_HEIGHT-1];
  logic [8:0]    cfg_w;
  logic [8:0]    cfg_h;
  logic [7:0]    cfg_bg;
  pixel_result_t expected_pixels [$];

  function automatic pixel_result_t canvas_response(canvas_req_t rq);
    pixel_result_t res;
    int            used_w;
    int            used_h;
    longint        r;
    longint        ri;
    longint        outer;
    longint        inner;
    longint        dx;
    longint        dy;
    longint        d2;
    bit            ring;
    res = '0;
    used_w = (cfg_w > MAX_WIDTH) ? MAX_WIDTH : int'(cfg_w);
    used_h = (cfg_h > MAX_HEIGHT) ? MAX_HEIGHT : int'(cfg_h);
    case (rq.cmd)
      CMD_CLEAR: begin
        for (int row = 0; row < used_h; row++)
          for (int col = 0; col < used_w; col++)
            canvas_mem[row*MAX_WIDTH + col] = cfg_bg;
      end
      CMD_DRAW: begin
        r = rq.radius;
        if ((rq.shape != SHAPE_FILLED && rq.shape != SHAPE_RING) || r <= 0) begin
          res.err = 1'b1;
        end else begin
          outer = r * r;
          ri = r - ONE_Q8;
          // below one unit the inner edge never excludes anything
          ring = (rq.shape == SHAPE_RING) && (ri >= 0);
          inner = ri * ri;
          for (int row = 0; row < used_h; row++) begin
            dy = longint'(row) * ONE_Q8 - longint'(rq.cy);
            for (int col = 0; col < used_w; col++) begin
              dx = longint'(col) * ONE_Q8 - longint'(rq.cx);
              d2 = dx * dx + dy * dy;
              if (d2 <= outer && (!ring || d2 > inner))
                canvas_mem[row*MAX_WIDTH + col] = rq.paint;
            end
          end
        end
      end
      CMD_READ: begin
        if (int'(rq.col) >= used_w || int'(rq.row) >= used_h)
          res.err = 1'b1;
        else
          res.pixel = canvas_mem[int'(rq.row)*MAX_WIDTH + int'(rq.col)];
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic note_failure(string msg);
    fail_count++;
    if (fail_count <= 10)
      $display("%0t: %s", $realtime, msg);
  endtask

  always @(posedge clk) begin : monitor
    canvas_req_t   rq;
    pixel_result_t got;
    pixel_result_t want;
    if (rst) begin
      expected_pixels.delete();
      cfg_w = RESET_WIDTH;
      cfg_h = RESET_HEIGHT;
      cfg_bg = RESET_BG;
      fail_count = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.pixel = m_tdata;
        got.err = m_tuser[0];
        if (expected_pixels.size() == 0) begin
          note_failure($sformatf("result with no request pending: pixel %02h error %0d",
                                 got.pixel, got.err));
        end else begin
          want = expected_pixels.pop_front();
          if (got.pixel !== want.pixel || got.err !== want.err)
            note_failure($sformatf("mismatch: expected pixel %02h error %0d, got pixel %02h error %0d",
                                   want.pixel, want.err, got.pixel, got.err));
        end
      end
      if (s_tvalid && s_tready) begin
        rq.cmd = s_tuser;
        rq.shape = s_tdata[7:0];
        rq.cx = s_tdata[26:8];
        rq.cy = s_tdata[45:27];
        rq.radius = s_tdata[64:46];
        rq.paint = s_tdata[72:65];
        rq.col = s_tdata[80:73];
        rq.row = s_tdata[88:81];
        expected_pixels.push_back(canvas_response(rq));
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_WIDTH:  cfg_w = cfg_wdata;
          CFG_HEIGHT: cfg_h = cfg_wdata;
          CFG_BG:     cfg_bg = cfg_wdata[7:0];
          default: ;
        endcase
      end
    end
    outstanding <= expected_pixels.size();
  end

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives the circle canvas rasteriser with directed clears, draws and reads
// across several canvas settings, then randomised request phases with bursty
// input, a stalling result port and one long result hold-off. Checking is
// done by canvas_checker; this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
  import ccr_pkg::*;

  localparam logic [1:0] CMD_UNUSED   = 2'd3;
  localparam int         HOLD_CYCLES  = 400;
  localparam int         STALL_LIMIT  = 250000;
  localparam int         RANDOM_ITEMS = 70;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [95:0] s_tdata = '0;
  logic [1:0]  s_tuser = CMD_CLEAR;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic [0:0]  m_tuser;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_WIDTH;
  logic [8:0]  cfg_wdata = '0;

  int fail_count;
  int outstanding;
  int hold_requests = 0;
  int quiet_cycles = 0;
  int burst_left = 0;
  bit gapless = 1'b0;
  int cur_w = 256;
  int cur_h = 256;

  always #5 clk = ~clk;

  circle_canvas_rasterizer dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  canvas_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .outstanding(outstanding)
  );

  function automatic logic [95:0] pack_operands(logic [7:0] shape, logic [18:0] cx,
                                                logic [18:0] cy, logic [18:0] radius,
                                                logic [7:0] paint, logic [7:0] col,
                                                logic [7:0] row);
    return {7'd0, row, col, paint, radius, cy, cx, shape};
  endfunction

  function automatic logic [95:0] noise_operands();
    return pack_operands(8'($urandom), 19'($urandom), 19'($urandom), 19'($urandom),
                         8'($urandom), 8'($urandom), 8'($urandom));
  endfunction

  // called right after a rising edge; holds tvalid across back-to-back requests
  task automatic send_request(input logic [1:0] cmd, input logic [95:0] operands);
    int gap;
    if (!gapless && burst_left == 0) begin
      gap = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 12);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    if (burst_left > 0)
      burst_left--;
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= operands;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic clear_canvas();
    send_request(CMD_CLEAR, noise_operands());
  endtask

  task automatic draw_circle(logic [7:0] shape, int cx, int cy, int radius, logic [7:0] paint);
    send_request(CMD_DRAW, pack_operands(shape, cx[18:0], cy[18:0], radius[18:0], paint,
                                         8'($urandom), 8'($urandom)));
  endtask

  task automatic read_pixel(logic [7:0] col, logic [7:0] row);
    send_request(CMD_READ, pack_operands(8'($urandom), 19'($urandom), 19'($urandom),
                                         19'($urandom), 8'($urandom), col, row));
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [8:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
  endtask

  task automatic set_canvas(int w, int h, logic [7:0] bg);
    write_reg(CFG_WIDTH, w[8:0]);
    write_reg(CFG_HEIGHT, h[8:0]);
    write_reg(CFG_BG, {1'b0, bg});
    cfg_we <= 1'b0;
    cur_w = (w > 256) ? 256 : w;
    cur_h = (h > 256) ? 256 : h;
  endtask

  task automatic random_request();
    int         p;
    int         span_w;
    int         span_h;
    int         reach;
    logic [7:0] shape;
    p = $urandom_range(0, 99);
    span_w = (cur_w == 0) ? 8 : cur_w;
    span_h = (cur_h == 0) ? 8 : cur_h;
    reach = ((span_w > span_h) ? span_w : span_h) + 2;
    if (p < 8) begin
      send_request(2'($urandom_range(0, 3)), noise_operands());
    end else if (p < 15) begin
      clear_canvas();
    end else if (p < 55) begin
      shape = $urandom_range(0, 1) ? SHAPE_FILLED : SHAPE_RING;
      draw_circle(shape, $urandom_range(0, (span_w + 4) * 256) - 512,
                  $urandom_range(0, (span_h + 4) * 256) - 512,
                  ($urandom_range(0, 3) == 0) ? $urandom_range(1, 300)
                                              : $urandom_range(1, reach * 256),
                  8'($urandom));
    end else if (cur_w != 0 && cur_h != 0 && $urandom_range(0, 3) != 0) begin
      read_pixel(8'($urandom_range(0, cur_w - 1)), 8'($urandom_range(0, cur_h - 1)));
    end else begin
      read_pixel(8'($urandom), 8'($urandom));
    end
  endtask

  // result side: stretches of ready, stall and random, plus the requested long hold-off
  initial begin : receiver
    int holds_done;
    int span;
    int style;
    holds_done = 0;
    @(posedge clk);
    forever begin
      if (hold_requests != holds_done) begin
        holds_done = hold_requests;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        span = $urandom_range(1, 24);
        style = $urandom_range(0, 4);
        repeat (span) begin
          m_tready <= (style < 2) ? 1'b1 : (style == 2) ? 1'b0 : 1'($urandom_range(0, 1));
          @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL circle_canvas_rasterizer");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int sent;
    int phase;
    int k;
    int w;
    int h;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: the first clear defines every pixel of the store
    clear_canvas();
    read_pixel(8'd0, 8'd0);
    read_pixel(8'd255, 8'd255);
    draw_circle(SHAPE_RING, 128*256, 128*256, 128*256, 8'h2A);
    read_pixel(8'd128, 8'd0);
    read_pixel(8'd128, 8'd128);

    wait_idle();
    set_canvas(8, 6, 8'h00);
    clear_canvas();
    read_pixel(8'd7, 8'd5);
    read_pixel(8'd8, 8'd0);
    read_pixel(8'd0, 8'd6);
    draw_circle(SHAPE_FILLED, 896, 640, 512, 8'h41);
    draw_circle(SHAPE_RING, 0, 0, 128, 8'hFF);          // radius under one unit
    draw_circle(SHAPE_RING, 5*256, 3*256, 256, 8'h80);  // inner edge at the centre
    draw_circle(8'h58, 512, 512, 512, 8'h11);           // unknown shape
    draw_circle(SHAPE_FILLED, 512, 512, 0, 8'h22);
    draw_circle(SHAPE_RING, 512, 512, -262144, 8'h33);
    draw_circle(SHAPE_FILLED, -262144, 262143, 262143, 8'h55);
    send_request(CMD_UNUSED, {7'd0, {89{1'b1}}});
    read_pixel(8'd0, 8'd0);
    read_pixel(8'd3, 8'd2);

    wait_idle();
    set_canvas(0, 5, 8'hFF);
    clear_canvas();
    draw_circle(SHAPE_FILLED, 0, 0, 1024, 8'h66);
    read_pixel(8'd0, 8'd0);

    wait_idle();
    set_canvas(511, 2, 8'hFF);
    clear_canvas();
    draw_circle(SHAPE_RING, 200*256, 256, 3*256, 8'h99);
    read_pixel(8'd255, 8'd1);
    read_pixel(8'd0, 8'd2);

    wait_idle();
    set_canvas(2, 511, 8'h00);
    clear_canvas();
    read_pixel(8'd1, 8'd255);

    sent = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      wait_idle();
      if (phase == 2) begin
        // long result hold-off while requests keep coming
        set_canvas(8, 8, 8'($urandom));
        hold_requests <= hold_requests + 1;
        gapless = 1'b1;
        repeat (24) begin
          read_pixel(8'($urandom_range(0, 7)), 8'($urandom_range(0, 7)));
          sent++;
        end
      end else begin
        k = $urandom_range(0, 9);
        case (k)
          0: begin
            w = $urandom_range(0, 1) ? 0 : $urandom_range(1, 8);
            h = (w == 0) ? $urandom_range(0, 8) : 0;
          end
          1: begin
            w = $urandom_range(257, 511);
            h = $urandom_range(1, 2);
          end
          2: begin
            w = $urandom_range(1, 2);
            h = $urandom_range(257, 511);
          end
          3: begin
            w = 256;
            h = 1;
          end
          default: begin
            w = $urandom_range(1, 16);
            h = $urandom_range(1, 16);
          end
        endcase
        set_canvas(w, h, 8'($urandom));
        gapless = ($urandom_range(0, 3) == 0);
        repeat ($urandom_range(6, 14)) begin
          random_request();
          sent++;
        end
      end
      phase++;
    end

    wait_idle();
    if (fail_count == 0 && outstanding == 0)
      $display("PASS circle_canvas_rasterizer");
    else
      $display("FAIL circle_canvas_rasterizer");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/ccr_pkg.sv
hw/rtl/ccr_ram.sv
hw/rtl/ccr_datapath.sv
hw/rtl/ccr_ctrl.sv
hw/rtl/circle_canvas_rasterizer.sv
verif/canvas_checker.sv
verif/testbench.sv
